// ===== rtl/hsv_pixel_color_capper_top_defines.svh =====
// ----------------------------------------------------------------------------
// HSV pixel colour capper - assertion macros
// Shared assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HSV_PIXEL_COLOR_CAPPER_TOP_DEFINES_SVH
`define HSV_PIXEL_COLOR_CAPPER_TOP_DEFINES_SVH

// same-cycle implication
`define HSVCAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv capper check failed");

// next-cycle implication
`define HSVCAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv capper check failed");

`endif

// ===== rtl/hsvcap_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV pixel colour capper - package
// Stage payload types and hue region constants.
// ----------------------------------------------------------------------------
package hsvcap_pkg;

  typedef enum logic [2:0] {
    RGN_RED     = 3'd0,
    RGN_YELLOW  = 3'd1,
    RGN_GREEN   = 3'd2,
    RGN_CYAN    = 3'd3,
    RGN_BLUE    = 3'd4,
    RGN_MAGENTA = 3'd5
  } region_t;

  localparam logic [7:0] HUE_EDGE_1 = 8'd43;
  localparam logic [7:0] HUE_EDGE_2 = 8'd86;
  localparam logic [7:0] HUE_EDGE_3 = 8'd129;
  localparam logic [7:0] HUE_EDGE_4 = 8'd172;
  localparam logic [7:0] HUE_EDGE_5 = 8'd215;
  localparam logic [7:0] CH_MAX     = 8'd255;
  localparam logic [7:0] SCALE_RST  = 8'd64;

  typedef struct packed {
    logic        kind;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [7:0]  s;
    region_t     region;
    logic [7:0]  rem;
  } dec_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  v;
    logic        sat_zero;
    region_t     region;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;
  } pqt_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } pix_t;

endpackage

// ===== rtl/hsvcap_decode.sv =====
// ----------------------------------------------------------------------------
// HSV pixel colour capper - hue decode stage
// Range check on the index, hue region and remainder, one register stage.
// ----------------------------------------------------------------------------
module hsvcap_decode #(
  parameter int PIXEL_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_pixel_index,
  input  logic [7:0]        in_red_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_blue_in,
  input  logic [7:0]        in_hue,
  input  logic [7:0]        in_saturation,
  input  logic [7:0]        in_brightness_value,
  output logic              dec_valid,
  input  logic              dec_ready,
  output hsvcap_pkg::dec_t  dec_data
);

  logic                valid_r;
  hsvcap_pkg::dec_t    data_r;
  hsvcap_pkg::dec_t    data_nxt;
  hsvcap_pkg::region_t region;
  logic [7:0]          base;
  logic [7:0]          diff;
  logic                in_range;

  assign in_range = {1'b0, in_pixel_index} < 9'(PIXEL_COUNT);
  assign in_ready = !valid_r || dec_ready;

  always_comb begin
    if (in_hue < hsvcap_pkg::HUE_EDGE_1) begin
      region = hsvcap_pkg::RGN_RED;
      base   = 8'd0;
    end else if (in_hue < hsvcap_pkg::HUE_EDGE_2) begin
      region = hsvcap_pkg::RGN_YELLOW;
      base   = hsvcap_pkg::HUE_EDGE_1;
    end else if (in_hue < hsvcap_pkg::HUE_EDGE_3) begin
      region = hsvcap_pkg::RGN_GREEN;
      base   = hsvcap_pkg::HUE_EDGE_2;
    end else if (in_hue < hsvcap_pkg::HUE_EDGE_4) begin
      region = hsvcap_pkg::RGN_CYAN;
      base   = hsvcap_pkg::HUE_EDGE_3;
    end else if (in_hue < hsvcap_pkg::HUE_EDGE_5) begin
      region = hsvcap_pkg::RGN_BLUE;
      base   = hsvcap_pkg::HUE_EDGE_4;
    end else begin
      region = hsvcap_pkg::RGN_MAGENTA;
      base   = hsvcap_pkg::HUE_EDGE_5;
    end
    diff = in_hue - base;
    data_nxt.kind   = in_kind;
    data_nxt.idx    = in_pixel_index;
    data_nxt.r      = in_red_in;
    data_nxt.g      = in_green_in;
    data_nxt.b      = in_blue_in;
    data_nxt.v      = in_brightness_value;
    data_nxt.s      = in_saturation;
    data_nxt.region = region;
    // remainder times six, at most 252
    data_nxt.rem    = 8'({diff, 2'b00}) + 8'({diff, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

// ===== rtl/hsvcap_mul.sv =====
// ----------------------------------------------------------------------------
// HSV pixel colour capper - p, q, t product stages
// Two register stages: saturation products, then value products.
// ----------------------------------------------------------------------------
module hsvcap_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              dec_valid,
  output logic              dec_ready,
  input  hsvcap_pkg::dec_t  dec_data,
  output logic              pqt_valid,
  input  logic              pqt_ready,
  output hsvcap_pkg::pqt_t  pqt_data
);

  // stage A: p final, q and t factors
  logic              a_valid_r;
  logic              a_ready;
  hsvcap_pkg::pqt_t  a_r;
  hsvcap_pkg::pqt_t  a_nxt;
  logic [15:0]       p_prod;
  logic [15:0]       sq_prod;
  logic [15:0]       st_prod;
  // stage B: q and t
  logic              b_valid_r;
  hsvcap_pkg::pqt_t  b_r;
  hsvcap_pkg::pqt_t  b_nxt;
  logic [15:0]       q_prod;
  logic [15:0]       t_prod;

  assign dec_ready = !a_valid_r || a_ready;
  assign a_ready   = !b_valid_r || pqt_ready;

  always_comb begin
    p_prod  = 16'(dec_data.v) * 16'(hsvcap_pkg::CH_MAX - dec_data.s);
    sq_prod = 16'(dec_data.s) * 16'(dec_data.rem);
    st_prod = 16'(dec_data.s) * 16'(hsvcap_pkg::CH_MAX - dec_data.rem);
    a_nxt.kind     = dec_data.kind;
    a_nxt.idx      = dec_data.idx;
    a_nxt.r        = dec_data.r;
    a_nxt.g        = dec_data.g;
    a_nxt.b        = dec_data.b;
    a_nxt.v        = dec_data.v;
    a_nxt.sat_zero = dec_data.s == 8'd0;
    a_nxt.region   = dec_data.region;
    a_nxt.p        = p_prod[15:8];
    a_nxt.q        = hsvcap_pkg::CH_MAX - sq_prod[15:8];
    a_nxt.t        = hsvcap_pkg::CH_MAX - st_prod[15:8];
  end

  always_comb begin
    q_prod  = 16'(a_r.v) * 16'(a_r.q);
    t_prod  = 16'(a_r.v) * 16'(a_r.t);
    b_nxt   = a_r;
    b_nxt.q = q_prod[15:8];
    b_nxt.t = t_prod[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (dec_ready) begin
        a_valid_r <= dec_valid;
      end
      if (a_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      a_r <= a_nxt;
    end
    if (a_ready && a_valid_r) begin
      b_r <= b_nxt;
    end
  end

  assign pqt_valid = b_valid_r;
  assign pqt_data  = b_r;

endmodule

// ===== rtl/hsvcap_scale.sv =====
// ----------------------------------------------------------------------------
// HSV pixel colour capper - channel select and brightness cap
// Region arrangement and cap product, then the divide by 255 into the
// output register.
// ----------------------------------------------------------------------------
module hsvcap_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        scale,
  input  logic              pqt_valid,
  output logic              pqt_ready,
  input  hsvcap_pkg::pqt_t  pqt_data,
  output logic              pix_valid,
  input  logic              pix_ready,
  output hsvcap_pkg::pix_t  pix_data
);

  logic              m_valid_r;
  logic              m_ready;
  logic [7:0]        m_idx_r;
  logic [15:0]       m_r_r;
  logic [15:0]       m_g_r;
  logic [15:0]       m_b_r;
  logic [7:0]        sel_r;
  logic [7:0]        sel_g;
  logic [7:0]        sel_b;
  logic              o_valid_r;
  hsvcap_pkg::pix_t  o_r;
  hsvcap_pkg::pix_t  o_nxt;

  // x / 255 for any product of two 8-bit values: (x + (x >> 8) + 1) >> 8
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + 16'(x[15:8]) + 16'd1;
    return sum[15:8];
  endfunction

  assign pqt_ready = !m_valid_r || m_ready;
  assign m_ready   = !o_valid_r || pix_ready;

  always_comb begin
    if (!pqt_data.kind) begin
      sel_r = pqt_data.r;
      sel_g = pqt_data.g;
      sel_b = pqt_data.b;
    end else if (pqt_data.sat_zero) begin
      sel_r = pqt_data.v;
      sel_g = pqt_data.v;
      sel_b = pqt_data.v;
    end else begin
      unique case (pqt_data.region)
        hsvcap_pkg::RGN_RED: begin
          sel_r = pqt_data.v; sel_g = pqt_data.t; sel_b = pqt_data.p;
        end
        hsvcap_pkg::RGN_YELLOW: begin
          sel_r = pqt_data.q; sel_g = pqt_data.v; sel_b = pqt_data.p;
        end
        hsvcap_pkg::RGN_GREEN: begin
          sel_r = pqt_data.p; sel_g = pqt_data.v; sel_b = pqt_data.t;
        end
        hsvcap_pkg::RGN_CYAN: begin
          sel_r = pqt_data.p; sel_g = pqt_data.q; sel_b = pqt_data.v;
        end
        hsvcap_pkg::RGN_BLUE: begin
          sel_r = pqt_data.t; sel_g = pqt_data.p; sel_b = pqt_data.v;
        end
        default: begin
          sel_r = pqt_data.v; sel_g = pqt_data.p; sel_b = pqt_data.q;
        end
      endcase
    end
  end

  always_comb begin
    o_nxt.idx = m_idx_r;
    o_nxt.r   = div255(m_r_r);
    o_nxt.g   = div255(m_g_r);
    o_nxt.b   = div255(m_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (pqt_ready) begin
        m_valid_r <= pqt_valid;
      end
      if (m_ready) begin
        o_valid_r <= m_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pqt_ready && pqt_valid) begin
      m_idx_r <= pqt_data.idx;
      m_r_r   <= 16'(sel_r) * 16'(scale);
      m_g_r   <= 16'(sel_g) * 16'(scale);
      m_b_r   <= 16'(sel_b) * 16'(scale);
    end
    if (m_ready && m_valid_r) begin
      o_r <= o_nxt;
    end
  end

  assign pix_valid = o_valid_r;
  assign pix_data  = o_r;

endmodule

// ===== rtl/hsv_pixel_color_capper_top.sv =====
// ----------------------------------------------------------------------------
// HSV pixel colour capper - top level
// Throughput 1 item/cycle while the output is not blocked.
// Five register stages (decode, two product stages, cap product, divide);
// each stage stalls only when it is full and the next one is blocked.
// Items with an index at or beyond PIXEL_COUNT are dropped at decode.
// Synchronous active-low reset empties the pipeline and sets the cap to 64.
// ----------------------------------------------------------------------------
`include "hsv_pixel_color_capper_top_defines.svh"

module hsv_pixel_color_capper_top #(
  parameter int PIXEL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_brightness_scale,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_pixel_index,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_hue,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_out,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out
);

  logic              [7:0] scale_r;
  logic              dec_valid;
  logic              dec_ready;
  hsvcap_pkg::dec_t  dec_data;
  logic              pqt_valid;
  logic              pqt_ready;
  hsvcap_pkg::pqt_t  pqt_data;
  hsvcap_pkg::pix_t  pix_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= hsvcap_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_brightness_scale;
    end
  end

  hsvcap_decode #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_decode (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_pixel_index      (in_pixel_index),
    .in_red_in           (in_red_in),
    .in_green_in         (in_green_in),
    .in_blue_in          (in_blue_in),
    .in_hue              (in_hue),
    .in_saturation       (in_saturation),
    .in_brightness_value (in_brightness_value),
    .dec_valid           (dec_valid),
    .dec_ready           (dec_ready),
    .dec_data            (dec_data)
  );

  hsvcap_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .pqt_valid (pqt_valid),
    .pqt_ready (pqt_ready),
    .pqt_data  (pqt_data)
  );

  hsvcap_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .scale     (scale_r),
    .pqt_valid (pqt_valid),
    .pqt_ready (pqt_ready),
    .pqt_data  (pqt_data),
    .pix_valid (out_valid),
    .pix_ready (out_ready),
    .pix_data  (pix_data)
  );

  assign out_pixel_out = pix_data.idx;
  assign out_red_out   = pix_data.r;
  assign out_green_out = pix_data.g;
  assign out_blue_out  = pix_data.b;

  // only in-range items reach the output
  `HSVCAP_ASSERT_NOW(a_out_in_range, out_valid, {1'b0, out_pixel_out} < 9'(PIXEL_COUNT))
  // input back-pressure only when every stage is full and the output is blocked
  `HSVCAP_ASSERT_NOW(a_stall_chain, !in_ready, out_valid && !out_ready && dec_valid && pqt_valid)
  `HSVCAP_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, scale_r == $past(cfg_brightness_scale))

endmodule
